// File: rtl/tags_pkg.sv
// ----------------------------------------------------------------------------
// tags_pkg
// Shared types, constants and helpers of the topic assignment Gibbs sampler.
// ----------------------------------------------------------------------------
package tags_pkg;

    localparam int NUM_TOPICS    = 64;
    localparam int TOPIC_BITS    = $clog2(NUM_TOPICS);
    localparam int VOCAB_SIZE    = 4096;
    localparam int WORD_BITS     = $clog2(VOCAB_SIZE);
    localparam int COUNT_BITS    = 20;
    localparam int FRAC_BITS     = 16;
    localparam int WEIGHT_BITS   = 32;
    localparam int UNI_BITS      = 32;
    localparam int KIND_BITS     = 3;
    localparam int WTC_ADDR_BITS = WORD_BITS + TOPIC_BITS;
    localparam int SCORE_BITS    = 64;
    localparam int ACC_BITS      = 2 * SCORE_BITS;
    localparam int MUL_BITS      = 32;

    localparam logic [WEIGHT_BITS-1:0] BETA_RESET = 32'd6554;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ADD      = 3'd0,
        KIND_PRIOR    = 3'd1,
        KIND_TWEIGHT  = 3'd2,
        KIND_RESAMPLE = 3'd3,
        KIND_READ     = 3'd4
    } kind_t;

    // command from the sequencer to the shared arithmetic unit
    typedef struct packed {
        logic                  mul_en;
        logic                  mul_clr;
        logic [MUL_BITS-1:0]   mul_a;
        logic [MUL_BITS-1:0]   mul_b;
        logic [1:0]            mul_sh;     // partial product weight, units of 32 bits
        logic                  div_start;
        logic [SCORE_BITS-1:0] den;
    } md_cmd_t;

    typedef struct packed {
        logic                  div_busy;
        logic [SCORE_BITS-1:0] quot;
        logic [ACC_BITS-1:0]   acc;
    } md_stat_t;

    function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] c);
        cnt_inc = (&c) ? c : c + 1'b1;
    endfunction

    function automatic logic [COUNT_BITS-1:0] cnt_dec(input logic [COUNT_BITS-1:0] c);
        cnt_dec = (c == '0) ? c : c - 1'b1;
    endfunction

    function automatic logic [SCORE_BITS-1:0] sat_add(input logic [SCORE_BITS-1:0] a,
                                                      input logic [SCORE_BITS-1:0] b);
        logic [SCORE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[SCORE_BITS] ? '1 : s[SCORE_BITS-1:0];
    endfunction

endpackage

// File: rtl/tags_ram.sv
// ----------------------------------------------------------------------------
// tags_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tags_ram #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/tags_muldiv.sv
// ----------------------------------------------------------------------------
// tags_muldiv
// Shared 32x32 multiply-accumulate and bit-serial restoring divider.
// ----------------------------------------------------------------------------
module tags_muldiv
    import tags_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  md_cmd_t  cmd,
    output md_stat_t stat
);

    logic [ACC_BITS-1:0]   acc_reg, acc_next;
    logic [SCORE_BITS:0]   rem_reg, rem_next;
    logic [SCORE_BITS-1:0] lo_reg, lo_next;
    logic [SCORE_BITS-1:0] quot_reg, quot_next;
    logic [SCORE_BITS-1:0] den_reg, den_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;

    logic [2*MUL_BITS-1:0] prod;
    logic [ACC_BITS-1:0]   addend;
    logic [SCORE_BITS:0]   shifted;

    assign prod    = cmd.mul_a * cmd.mul_b;
    assign addend  = ACC_BITS'(prod) << {cmd.mul_sh, 5'd0};
    assign shifted = {rem_reg[SCORE_BITS-1:0], lo_reg[SCORE_BITS-1]};

    always_comb begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (cmd.mul_en) begin
            acc_next = (cmd.mul_clr ? '0 : acc_reg) + addend;
        end
        if (cmd.div_start) begin
            den_next = cmd.den;
            if (cmd.den == '0) begin
                quot_next = '0;
            end else if (acc_reg[ACC_BITS-1:SCORE_BITS] >= cmd.den) begin
                quot_next = '1;     // quotient overflows: saturate
            end else begin
                rem_next  = {1'b0, acc_reg[ACC_BITS-1:SCORE_BITS]};
                lo_next   = acc_reg[SCORE_BITS-1:0];
                quot_next = '0;
                cnt_next  = '0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            lo_next = {lo_reg[SCORE_BITS-2:0], 1'b0};
            if (shifted >= {1'b0, den_reg}) begin
                rem_next  = shifted - {1'b0, den_reg};
                quot_next = {quot_reg[SCORE_BITS-2:0], 1'b1};
            end else begin
                rem_next  = shifted;
                quot_next = {quot_reg[SCORE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (&cnt_reg) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign stat.div_busy = busy_reg;
    assign stat.quot     = quot_reg;
    assign stat.acc      = acc_reg;

endmodule

// File: rtl/topic_assignment_gibbs_sampler.sv
// ----------------------------------------------------------------------------
// topic_assignment_gibbs_sampler
// Collapsed Gibbs topic sampler with count tables and one shared
// multiply/divide unit run by a sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  ports                         content
//  s_       in   s_tvalid/s_tready/s_tdata/    one command item
//                s_tuser
//  m_       out  m_tvalid/m_tready/m_tdata     one result item
//  cfg_     in   cfg_valid/cfg_ready/cfg_data  beta smoothing register
//
//  After reset the block sweeps all 262144 entries of the word-by-topic table,
//  one entry a cycle, before s_tready first rises (config writes still taken).
//  Add: read and increment the counts, no result. Set prior / time weight:
//  written straight from the accepted item. Read counts: read, then OUT.
//  Resample: decrement, then per topic 4 partial products and up to 64 divide
//  steps on the shared unit, then a threshold product, search and increment.
//  One item at a time; a finished result sits in the output register while
//  the next item is accepted. A stalled m_tready holds only the OUT step.
// ----------------------------------------------------------------------------
module topic_assignment_gibbs_sampler
    import tags_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // item transfer
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // word[11:0], topic[17:12], weight[49:18], uniform[81:50]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    // result transfer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // new_topic[5:0], word_topic_count[25:6],
                                   // topic_total_count[45:26], doc_topic_count[65:46]
    // configuration transfer
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    typedef enum logic [18:0] {
        ST_CLEAR    = 19'h00001,
        ST_IDLE     = 19'h00002,
        ST_DEC_RD   = 19'h00004,
        ST_DEC_WR   = 19'h00008,
        ST_SC_RD    = 19'h00010,
        ST_SC_W     = 19'h00020,
        ST_SC_WSAVE = 19'h00040,
        ST_SC_MUL   = 19'h00080,
        ST_SC_DSTART= 19'h00100,
        ST_SC_DIV   = 19'h00200,
        ST_SC_STORE = 19'h00400,
        ST_TH_MUL   = 19'h00800,
        ST_TH_SAVE  = 19'h01000,
        ST_SCAN_RD  = 19'h02000,
        ST_SCAN_CHK = 19'h04000,
        ST_INC_RD   = 19'h08000,
        ST_INC_WR   = 19'h10000,
        ST_READ     = 19'h20000,
        ST_OUT      = 19'h40000
    } state_t;

    // input fields
    logic [WORD_BITS-1:0]   in_word;
    logic [TOPIC_BITS-1:0]  in_topic;
    logic [WEIGHT_BITS-1:0] in_weight;
    logic [UNI_BITS-1:0]    in_uni;
    assign in_word   = s_tdata[11:0];
    assign in_topic  = s_tdata[17:12];
    assign in_weight = s_tdata[49:18];
    assign in_uni    = s_tdata[81:50];

    state_t                  state_reg, state_next;
    logic [WTC_ADDR_BITS-1:0] clr_reg, clr_next;
    logic [WEIGHT_BITS-1:0]  beta_reg, beta_next;
    logic                    m_valid_reg, m_valid_next;
    logic [71:0]             m_data_reg, m_data_next;
    logic [WORD_BITS-1:0]    word_reg, word_next;
    logic [TOPIC_BITS-1:0]   topic_reg, topic_next;
    logic [UNI_BITS-1:0]     uni_reg, uni_next;
    logic                    res_reg, res_next;     // item is a resample
    logic [TOPIC_BITS-1:0]   k_reg, k_next;
    logic [TOPIC_BITS-1:0]   pick_reg, pick_next;
    logic [1:0]              j_reg, j_next;
    logic [47:0]             w_reg, w_next;         // prior*timeweight, Q32.16
    logic [SCORE_BITS-1:0]   n_reg, n_next;
    logic [SCORE_BITS-1:0]   d_reg, d_next;
    logic [SCORE_BITS-1:0]   sum_reg, sum_next;
    logic [SCORE_BITS-1:0]   cum_reg, cum_next;
    logic [SCORE_BITS-1:0]   thr_reg, thr_next;

    md_cmd_t  md_cmd;
    md_stat_t md_stat;

    // table ports
    logic                     clr_lo;       // sweep is inside the small tables
    logic [TOPIC_BITS-1:0]    rd_topic, wr_topic;
    logic                     cnt_we;
    logic [WTC_ADDR_BITS-1:0] wtc_waddr;
    logic [COUNT_BITS-1:0]    wtc_wdata, tot_wdata, doc_wdata;
    logic [COUNT_BITS-1:0]    wtc_rdata, tot_rdata, doc_rdata;
    logic                     tot_we;
    logic [TOPIC_BITS-1:0]    small_waddr;
    logic                     pri_we, tw_we;
    logic [TOPIC_BITS-1:0]    wgt_waddr;
    logic [WEIGHT_BITS-1:0]   wgt_wdata;
    logic [WEIGHT_BITS-1:0]   pri_rdata, tw_rdata;
    logic                     sc_we;
    logic [SCORE_BITS-1:0]    sc_rdata;
    logic [SCORE_BITS-1:0]    cum_sum;
    logic                     s_xfer;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign clr_lo = (clr_reg[WTC_ADDR_BITS-1:TOPIC_BITS] == '0);

    always_comb begin
        case (state_reg)
            ST_SC_RD:  rd_topic = k_reg;
            ST_INC_RD: rd_topic = pick_reg;
            default:   rd_topic = topic_reg;
        endcase
    end

    assign wr_topic = (state_reg == ST_INC_WR) ? pick_reg : topic_reg;
    assign cnt_we   = (state_reg == ST_CLEAR) || (state_reg == ST_DEC_WR)
                    || (state_reg == ST_INC_WR);
    assign tot_we   = (state_reg == ST_CLEAR) ? clr_lo : cnt_we;
    assign wtc_waddr   = (state_reg == ST_CLEAR) ? clr_reg : {word_reg, wr_topic};
    assign small_waddr = (state_reg == ST_CLEAR) ? clr_reg[TOPIC_BITS-1:0] : wr_topic;

    always_comb begin
        case (state_reg)
            ST_DEC_WR: begin
                wtc_wdata = cnt_dec(wtc_rdata);
                tot_wdata = cnt_dec(tot_rdata);
                doc_wdata = cnt_dec(doc_rdata);
            end
            ST_INC_WR: begin
                wtc_wdata = cnt_inc(wtc_rdata);
                tot_wdata = cnt_inc(tot_rdata);
                doc_wdata = cnt_inc(doc_rdata);
            end
            default: begin
                wtc_wdata = '0;
                tot_wdata = '0;
                doc_wdata = '0;
            end
        endcase
    end

    // prior and time weight tables: loaded straight from the accepted item
    assign pri_we    = (state_reg == ST_CLEAR) ? clr_lo
                     : (s_xfer && s_tuser == KIND_PRIOR);
    assign tw_we     = (state_reg == ST_CLEAR) ? clr_lo
                     : (s_xfer && s_tuser == KIND_TWEIGHT);
    assign wgt_waddr = (state_reg == ST_CLEAR) ? clr_reg[TOPIC_BITS-1:0] : in_topic;
    assign wgt_wdata = (state_reg == ST_CLEAR) ? '0 : in_weight;
    assign sc_we     = (state_reg == ST_SC_STORE);

    tags_ram #(.ADDR_BITS(WTC_ADDR_BITS), .DATA_BITS(COUNT_BITS)) u_wtc (
        .aclk(aclk), .we(cnt_we), .waddr(wtc_waddr), .wdata(wtc_wdata),
        .raddr({word_reg, rd_topic}), .rdata(wtc_rdata));

    tags_ram #(.ADDR_BITS(TOPIC_BITS), .DATA_BITS(COUNT_BITS)) u_tot (
        .aclk(aclk), .we(tot_we), .waddr(small_waddr), .wdata(tot_wdata),
        .raddr(rd_topic), .rdata(tot_rdata));

    tags_ram #(.ADDR_BITS(TOPIC_BITS), .DATA_BITS(COUNT_BITS)) u_doc (
        .aclk(aclk), .we(tot_we), .waddr(small_waddr), .wdata(doc_wdata),
        .raddr(rd_topic), .rdata(doc_rdata));

    tags_ram #(.ADDR_BITS(TOPIC_BITS), .DATA_BITS(WEIGHT_BITS)) u_pri (
        .aclk(aclk), .we(pri_we), .waddr(wgt_waddr), .wdata(wgt_wdata),
        .raddr(rd_topic), .rdata(pri_rdata));

    tags_ram #(.ADDR_BITS(TOPIC_BITS), .DATA_BITS(WEIGHT_BITS)) u_tw (
        .aclk(aclk), .we(tw_we), .waddr(wgt_waddr), .wdata(wgt_wdata),
        .raddr(rd_topic), .rdata(tw_rdata));

    // per-topic scores of the current resample; written before being read
    tags_ram #(.ADDR_BITS(TOPIC_BITS), .DATA_BITS(SCORE_BITS)) u_score (
        .aclk(aclk), .we(sc_we), .waddr(k_reg), .wdata(md_stat.quot),
        .raddr(k_reg), .rdata(sc_rdata));

    tags_muldiv u_md (
        .aclk(aclk), .aresetn(aresetn), .cmd(md_cmd), .stat(md_stat));

    assign cum_sum = sat_add(cum_reg, sc_rdata);

    // shared unit operand selection
    always_comb begin
        md_cmd           = '0;
        md_cmd.den       = d_reg;
        case (state_reg)
            ST_SC_W: begin
                md_cmd.mul_en  = 1'b1;
                md_cmd.mul_clr = 1'b1;
                md_cmd.mul_a   = pri_rdata;
                md_cmd.mul_b   = tw_rdata;
            end
            ST_SC_MUL: begin
                // w * n as four 32x32 partial products
                md_cmd.mul_en  = 1'b1;
                md_cmd.mul_clr = (j_reg == 2'd0);
                md_cmd.mul_a   = j_reg[0] ? {16'd0, w_reg[47:32]} : w_reg[31:0];
                md_cmd.mul_b   = j_reg[1] ? n_reg[63:32] : n_reg[31:0];
                md_cmd.mul_sh  = {1'b0, j_reg[0]} + {1'b0, j_reg[1]};
            end
            ST_SC_DSTART: begin
                md_cmd.div_start = 1'b1;
            end
            ST_TH_MUL: begin
                // sum * uniform, keep bits 95:32
                md_cmd.mul_en  = 1'b1;
                md_cmd.mul_clr = (j_reg == 2'd0);
                md_cmd.mul_a   = j_reg[0] ? sum_reg[63:32] : sum_reg[31:0];
                md_cmd.mul_b   = uni_reg;
                md_cmd.mul_sh  = {1'b0, j_reg[0]};
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        beta_next    = beta_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        word_next    = word_reg;
        topic_next   = topic_reg;
        uni_next     = uni_reg;
        res_next     = res_reg;
        k_next       = k_reg;
        pick_next    = pick_reg;
        j_next       = j_reg;
        w_next       = w_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        sum_next     = sum_reg;
        cum_next     = cum_reg;
        thr_next     = thr_reg;

        if (cfg_valid && cfg_ready) begin
            beta_next = cfg_data;
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_xfer) begin
                    word_next  = in_word;
                    topic_next = in_topic;
                    uni_next   = in_uni;
                    pick_next  = in_topic;
                    case (s_tuser)
                        KIND_ADD: begin
                            res_next   = 1'b0;
                            state_next = ST_INC_RD;
                        end
                        KIND_RESAMPLE: begin
                            res_next   = 1'b1;
                            state_next = ST_DEC_RD;
                        end
                        KIND_READ: begin
                            res_next   = 1'b0;
                            state_next = ST_READ;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DEC_RD: state_next = ST_DEC_WR;
            ST_DEC_WR: begin
                k_next     = '0;
                sum_next   = '0;
                state_next = ST_SC_RD;
            end
            ST_SC_RD: state_next = ST_SC_W;
            ST_SC_W: begin
                n_next = SCORE_BITS'({wtc_rdata, FRAC_BITS'(0)}) + SCORE_BITS'(beta_reg);
                d_next = SCORE_BITS'({tot_rdata, FRAC_BITS'(0)})
                       + (SCORE_BITS'(beta_reg) << WORD_BITS);
                state_next = ST_SC_WSAVE;
            end
            ST_SC_WSAVE: begin
                w_next     = md_stat.acc[FRAC_BITS+47:FRAC_BITS];
                j_next     = '0;
                state_next = ST_SC_MUL;
            end
            ST_SC_MUL: begin
                j_next = j_reg + 1'b1;
                if (&j_reg) begin
                    state_next = ST_SC_DSTART;
                end
            end
            ST_SC_DSTART: state_next = ST_SC_DIV;
            ST_SC_DIV: begin
                if (!md_stat.div_busy) begin
                    state_next = ST_SC_STORE;
                end
            end
            ST_SC_STORE: begin
                sum_next = sat_add(sum_reg, md_stat.quot);
                k_next   = k_reg + 1'b1;
                if (&k_reg) begin
                    j_next     = '0;
                    state_next = ST_TH_MUL;
                end else begin
                    state_next = ST_SC_RD;
                end
            end
            ST_TH_MUL: begin
                j_next = j_reg + 1'b1;
                if (j_reg[0]) begin
                    state_next = ST_TH_SAVE;
                end
            end
            ST_TH_SAVE: begin
                thr_next   = md_stat.acc[95:32];
                k_next     = '0;
                cum_next   = '0;
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD: state_next = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                cum_next = cum_sum;
                // first topic reaching the threshold; last topic if none does
                if (cum_sum >= thr_reg || (&k_reg)) begin
                    pick_next  = k_reg;
                    state_next = ST_INC_RD;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_INC_RD: state_next = ST_INC_WR;
            ST_INC_WR: state_next = res_reg ? ST_OUT : ST_IDLE;
            ST_READ:   state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    if (res_reg) begin
                        m_data_next = {6'd0, 60'd0, pick_reg};
                    end else begin
                        m_data_next = {6'd0, doc_rdata, tot_rdata, wtc_rdata, topic_reg};
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            beta_reg    <= BETA_RESET;
            m_valid_reg <= 1'b0;
            res_reg     <= 1'b0;
            k_reg       <= '0;
            j_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            beta_reg    <= beta_next;
            m_valid_reg <= m_valid_next;
            res_reg     <= res_next;
            k_reg       <= k_next;
            j_reg       <= j_next;
        end
        m_data_reg <= m_data_next;
        word_reg   <= word_next;
        topic_reg  <= topic_next;
        uni_reg    <= uni_next;
        pick_reg   <= pick_next;
        w_reg      <= w_next;
        n_reg      <= n_next;
        d_reg      <= d_next;
        sum_reg    <= sum_next;
        cum_reg    <= cum_next;
        thr_reg    <= thr_next;
    end

    // score is only stored once the divider has finished
    a_store_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SC_STORE) |-> !md_stat.div_busy)
        else $error("score stored while divider busy");

    // a new result only comes out of the OUT step
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside OUT");

    // the search never runs past the last topic
    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN_CHK && (&k_reg)) |=> (state_reg == ST_INC_RD))
        else $error("search ran past last topic");

endmodule
